// File: rtl/core/rsa_pkg.sv
package rsa_pkg;

  // Default geometry and trig precision.
  localparam int MAX_SRC_DIM_DEF    = 4096;
  localparam int MAX_DST_DIM_DEF    = 8192;
  localparam int TRIG_FRAC_BITS_DEF = 14;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COS_ANGLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_ANGLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd5;

endpackage

// File: rtl/core/rsa_offset.sv
module rsa_offset #(
  parameter int DW = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic [DW-1:0]        dst_x_i,
  input  logic [DW-1:0]        dst_y_i,
  input  logic [DW:0]          dst_width_i,
  input  logic [DW:0]          dst_height_i,
  output logic                 valid_o,
  output logic signed [DW+1:0] dx2_o,
  output logic signed [DW+1:0] dy2_o
);

  logic                 valid_r;
  logic signed [DW+1:0] dx2_r;
  logic signed [DW+1:0] dy2_r;
  logic [DW+1:0]        dx2_nxt;
  logic [DW+1:0]        dy2_nxt;

  // Offsets from the destination center, in half pixels.
  assign dx2_nxt = {1'b0, dst_x_i, 1'b0} - {1'b0, dst_width_i};
  assign dy2_nxt = {1'b0, dst_y_i, 1'b0} - {1'b0, dst_height_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx2_r <= $signed(dx2_nxt);
      dy2_r <= $signed(dy2_nxt);
    end
  end

  assign valid_o = valid_r;
  assign dx2_o   = dx2_r;
  assign dy2_o   = dy2_r;

endmodule

// File: rtl/core/rsa_rotate.sv
module rsa_rotate #(
  parameter int DW  = 13,
  parameter int SW  = 12,
  parameter int FB  = 14,
  parameter int TW  = FB + 2,
  parameter int DXW = DW + 2,
  parameter int PW  = TW + DXW,
  parameter int NW  = ((PW + 1 > SW + FB + 2) ? PW + 1 : SW + FB + 2) + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_i,
  input  logic signed [DXW-1:0] dx2_i,
  input  logic signed [DXW-1:0] dy2_i,
  input  logic signed [TW-1:0]  cos_i,
  input  logic signed [TW-1:0]  sin_i,
  input  logic [SW:0]           src_width_i,
  input  logic [SW:0]           src_height_i,
  output logic                  valid_o,
  output logic signed [NW-1:0]  nx_o,
  output logic signed [NW-1:0]  ny_o
);

  logic                 prod_valid_r;
  logic signed [PW-1:0] pxc_r;
  logic signed [PW-1:0] pys_r;
  logic signed [PW-1:0] pyc_r;
  logic signed [PW-1:0] pxs_r;
  logic                 sum_valid_r;
  logic signed [NW-1:0] nx_r;
  logic signed [NW-1:0] ny_r;
  logic signed [NW-1:0] nx_nxt;
  logic signed [NW-1:0] ny_nxt;
  logic signed [NW-1:0] cx_off;
  logic signed [NW-1:0] cy_off;

  // Source center, in half pixels, scaled up to the numerator's fraction.
  assign cx_off = NW'($signed({1'b0, src_width_i, {FB{1'b0}}}));
  assign cy_off = NW'($signed({1'b0, src_height_i, {FB{1'b0}}}));

  assign nx_nxt = NW'(pxc_r) + NW'(pys_r) + cx_off;
  assign ny_nxt = NW'(pyc_r) - NW'(pxs_r) + cy_off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      sum_valid_r  <= 1'b0;
    end else if (en) begin
      prod_valid_r <= valid_i;
      sum_valid_r  <= prod_valid_r;
    end
  end

  // Four independent products, then the two sums one stage later.
  always_ff @(posedge clk) begin
    if (en) begin
      pxc_r <= cos_i * dx2_i;
      pys_r <= sin_i * dy2_i;
      pyc_r <= cos_i * dy2_i;
      pxs_r <= sin_i * dx2_i;
      nx_r  <= nx_nxt;
      ny_r  <= ny_nxt;
    end
  end

  assign valid_o = sum_valid_r;
  assign nx_o    = nx_r;
  assign ny_o    = ny_r;

endmodule

// File: rtl/core/rsa_bound.sv
module rsa_bound #(
  parameter int SW = 12,
  parameter int FB = 14,
  parameter int NW = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic signed [NW-1:0] nx_i,
  input  logic signed [NW-1:0] ny_i,
  input  logic [SW:0]          src_width_i,
  input  logic [SW:0]          src_height_i,
  output logic                 valid_o,
  output logic [SW-1:0]        src_x_o,
  output logic [SW-1:0]        src_y_o,
  output logic                 inside_o
);

  localparam int QW = NW - FB - 1;

  logic [QW-1:0]  qx;
  logic [QW-1:0]  qy;
  logic           ok_x;
  logic           ok_y;
  logic [SW-1:0]  sx;
  logic [SW-1:0]  sy;
  logic           valid_r;
  logic [SW-1:0]  src_x_r;
  logic [SW-1:0]  src_y_r;
  logic           inside_r;

  // Floor division by the numerator scale; truncation toward zero only
  // matters for negatives, where anything above minus one becomes zero.
  assign qx = nx_i[NW-1:FB+1];
  assign qy = ny_i[NW-1:FB+1];

  always_comb begin
    if (nx_i[NW-1]) begin
      sx   = '0;
      ok_x = (&qx) && (nx_i[FB:0] != '0);
    end else begin
      sx   = qx[SW-1:0];
      ok_x = (qx[QW-1:SW] == '0);
    end
    if (ny_i[NW-1]) begin
      sy   = '0;
      ok_y = (&qy) && (ny_i[FB:0] != '0);
    end else begin
      sy   = qy[SW-1:0];
      ok_y = (qy[QW-1:SW] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside_r <= ok_x && ok_y && ({1'b0, sx} < src_width_i) && ({1'b0, sy} < src_height_i);
      src_x_r  <= (ok_x && ok_y && ({1'b0, sx} < src_width_i) &&
                   ({1'b0, sy} < src_height_i)) ? sx : '0;
      src_y_r  <= (ok_x && ok_y && ({1'b0, sx} < src_width_i) &&
                   ({1'b0, sy} < src_height_i)) ? sy : '0;
    end
  end

  assign valid_o  = valid_r;
  assign src_x_o  = src_x_r;
  assign src_y_o  = src_y_r;
  assign inside_o = inside_r;

endmodule

// File: rtl/core/rotation_source_address.sv
// Source address generator for nearest-neighbor image rotation. Each item is
// one destination pixel (in_dst_x, in_dst_y); the block maps it back through
// the inverse rotation given by the cos_angle and sin_angle registers (signed,
// TRIG_FRAC_BITS fraction bits) around the image centers, truncates toward
// zero, and returns the source pixel together with out_inside_res. When the
// source pixel falls outside the source image, inside_res is 0 and both
// coordinates read 0; the caller paints that pixel black. The block takes one
// item every clock unless the result side stalls, and passes it on in order:
// one stage forms the centered offsets, one holds the four products of the
// rotation, one adds them to the source center, and one truncates, bounds and
// registers the result. A stall on the result side freezes the whole
// pipeline, so no item is lost or repeated. Configuration registers take
// effect at once and must be written only while no item is in flight.
module rotation_source_address #(
  parameter int MAX_SRC_DIM    = rsa_pkg::MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM    = rsa_pkg::MAX_DST_DIM_DEF,
  parameter int TRIG_FRAC_BITS = rsa_pkg::TRIG_FRAC_BITS_DEF,
  parameter int SW             = $clog2(MAX_SRC_DIM),
  parameter int DW             = $clog2(MAX_DST_DIM),
  parameter int TW             = TRIG_FRAC_BITS + 2,
  parameter int CW             = (TW > DW + 1) ? TW : DW + 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration writes.
  input  logic                           cfg_wr_en,
  input  logic [rsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [CW-1:0]                  cfg_wdata,
  // Destination pixel items.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [DW-1:0]                  in_dst_x,
  input  logic [DW-1:0]                  in_dst_y,
  // Source address items.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [SW-1:0]                  out_src_x,
  output logic [SW-1:0]                  out_src_y,
  output logic                           out_inside_res
);

  import rsa_pkg::*;

  localparam int DXW = DW + 2;
  localparam int PW  = TW + DXW;
  localparam int NW  = ((PW + 1 > SW + TRIG_FRAC_BITS + 2) ? PW + 1 :
                        SW + TRIG_FRAC_BITS + 2) + 1;

  logic signed [TW-1:0]  cos_r;
  logic signed [TW-1:0]  sin_r;
  logic [SW:0]           src_width_r;
  logic [SW:0]           src_height_r;
  logic [DW:0]           dst_width_r;
  logic [DW:0]           dst_height_r;

  logic                  en;
  logic                  s1_valid;
  logic signed [DXW-1:0] s1_dx2;
  logic signed [DXW-1:0] s1_dy2;
  logic                  s3_valid;
  logic signed [NW-1:0]  s3_nx;
  logic signed [NW-1:0]  s3_ny;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Configuration registers. Unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r        <= $signed(TW'(1) << TRIG_FRAC_BITS);
      sin_r        <= '0;
      src_width_r  <= (SW + 1)'(1);
      src_height_r <= (SW + 1)'(1);
      dst_width_r  <= (DW + 1)'(1);
      dst_height_r <= (DW + 1)'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COS_ANGLE:  cos_r        <= $signed(cfg_wdata[TW-1:0]);
        REG_SIN_ANGLE:  sin_r        <= $signed(cfg_wdata[TW-1:0]);
        REG_SRC_WIDTH:  src_width_r  <= cfg_wdata[SW:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_wdata[SW:0];
        REG_DST_WIDTH:  dst_width_r  <= cfg_wdata[DW:0];
        REG_DST_HEIGHT: dst_height_r <= cfg_wdata[DW:0];
        default: begin
        end
      endcase
    end
  end

  rsa_offset #(
    .DW (DW)
  ) u_offset (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .valid_i      (in_valid),
    .dst_x_i      (in_dst_x),
    .dst_y_i      (in_dst_y),
    .dst_width_i  (dst_width_r),
    .dst_height_i (dst_height_r),
    .valid_o      (s1_valid),
    .dx2_o        (s1_dx2),
    .dy2_o        (s1_dy2)
  );

  rsa_rotate #(
    .DW  (DW),
    .SW  (SW),
    .FB  (TRIG_FRAC_BITS),
    .TW  (TW),
    .DXW (DXW),
    .PW  (PW),
    .NW  (NW)
  ) u_rotate (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .valid_i      (s1_valid),
    .dx2_i        (s1_dx2),
    .dy2_i        (s1_dy2),
    .cos_i        (cos_r),
    .sin_i        (sin_r),
    .src_width_i  (src_width_r),
    .src_height_i (src_height_r),
    .valid_o      (s3_valid),
    .nx_o         (s3_nx),
    .ny_o         (s3_ny)
  );

  rsa_bound #(
    .SW (SW),
    .FB (TRIG_FRAC_BITS),
    .NW (NW)
  ) u_bound (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .valid_i      (s3_valid),
    .nx_i         (s3_nx),
    .ny_i         (s3_ny),
    .src_width_i  (src_width_r),
    .src_height_i (src_height_r),
    .valid_o      (out_valid),
    .src_x_o      (out_src_x),
    .src_y_o      (out_src_y),
    .inside_o     (out_inside_res)
  );

endmodule
